// ----- design/efss_pkg.sv -----
// Shared constants, types and control structs of the eased fade-and-slide sequencer.
package efss_pkg;

    // Fixed-point and timing resolution
    localparam int FRAC_BITS = 16;
    localparam int TIME_BITS = 24;

    // Field and register widths
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int DELTA_W   = 16;
    localparam int OPA_W     = 17;
    localparam int OFF_W     = 15;
    localparam int EL_W      = TIME_BITS + 1;
    localparam int CMP_W     = (EL_W > CFG_W) ? EL_W : CFG_W;
    localparam int MUL_W     = (FRAC_BITS + 1 > OFF_W) ? FRAC_BITS + 1 : OFF_W;
    localparam int DIV_CW    = $clog2(FRAC_BITS);

    // Opacity conversion to Q16
    localparam int Q16_RSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int Q16_LSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    // Fixed-point constants
    localparam logic [MUL_W-1:0] ONE_F    = MUL_W'(1) << FRAC_BITS;
    localparam logic [MUL_W-1:0] MAG_ENTER = MUL_W'(10240);
    localparam logic [MUL_W-1:0] MAG_EXIT  = MUL_W'(15360);
    localparam logic [OPA_W-1:0] OPA_ONE  = OPA_W'(65536);
    localparam logic [OPA_W-1:0] OPA_ZERO = '0;
    localparam logic signed [OFF_W-1:0] OFF_ENTER_START = -15'sd10240;
    localparam logic signed [OFF_W-1:0] OFF_EXIT_END    = -15'sd15360;
    localparam logic signed [OFF_W-1:0] OFF_ZERO        = '0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE    = 3'd4;

    // Sequencer phase
    typedef enum logic [1:0] {
        PH_HIDDEN   = 2'd0,
        PH_ENTERING = 2'd1,
        PH_VISIBLE  = 2'd2,
        PH_EXITING  = 2'd3
    } t_phase;

    // Operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MS_SQUARE = 2'd0,
        MS_CUBE   = 2'd1,
        MS_SCALE  = 2'd2
    } t_mul_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     publish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_ease;
        logic div_last;
    } t_stat;

endpackage

// ----- design/efss_dpath.sv -----
// Datapath: configuration, phase counters, restoring divider, shared multiplier, result beat.
module efss_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  efss_pkg::t_cmd                    i_cmd,
    output efss_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_we,
    input  logic [efss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [efss_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_func,
    input  logic [efss_pkg::DELTA_W-1:0]      i_step_ms,
    output logic [efss_pkg::OPA_W-1:0]        o_opacity_q16,
    output logic signed [efss_pkg::OFF_W-1:0] o_slide_offset_q8,
    output logic [1:0]                        o_phase,
    output logic                              o_active
);
    import efss_pkg::*;

    // Convert a Q(FRAC_BITS) opacity to Q16, round half up, clamp at one
    function automatic logic [OPA_W-1:0] to_q16(input logic [MUL_W-1:0] v);
        logic [MUL_W+16:0] w;
        logic [MUL_W+16:0] rnd;
        rnd = (MUL_W + 17)'((64'd1 << Q16_RSH) >> 1);
        if (FRAC_BITS >= 16) begin
            w = ((MUL_W + 17)'(v) + rnd) >> Q16_RSH;
        end else begin
            w = (MUL_W + 17)'(v) << Q16_LSH;
        end
        if (w > (MUL_W + 17)'(OPA_ONE)) begin
            return OPA_ONE;
        end
        return w[OPA_W-1:0];
    endfunction

    logic [CFG_W-1:0]        r_interval, r_enter, r_show, r_exit;
    logic                    r_force;
    t_phase                  r_phase, n_phase;
    logic [EL_W-1:0]         r_pel, n_pel, r_hel, n_hel;
    logic [OPA_W-1:0]        r_opa, n_opa;
    logic signed [OFF_W-1:0] r_off, n_off;
    logic                    r_need, n_need;
    logic                    r_curve_out, n_curve_out;
    logic [CFG_W-1:0]        r_dur, n_dur;
    logic [CFG_W-1:0]        r_rem, n_rem;
    logic [FRAC_BITS-1:0]    r_quo;
    logic [DIV_CW-1:0]       r_cnt;
    logic [MUL_W-1:0]        r_p;
    logic [OPA_W-1:0]        r_out_opa;
    logic signed [OFF_W-1:0] r_out_off;
    t_phase                  r_out_phase;
    logic                    r_out_active;

    logic [EL_W:0]           pel_sum, hel_sum;
    logic [EL_W-1:0]         pel_add, hel_add;
    logic [CFG_W-1:0]        dur_enter, dur_exit;
    logic [CFG_W:0]          rem2, rem_diff;
    logic                    rem_ge;
    logic [CFG_W-1:0]        rem_next;
    logic [MUL_W-1:0]        x_val, mag, mul_a, mul_b, mul_res;
    logic [2*MUL_W:0]        prod;
    logic [2*MUL_W:0]        prod_rnd;

    // Saturating elapsed counters
    assign pel_sum = {1'b0, r_pel} + (EL_W + 1)'(i_step_ms);
    assign hel_sum = {1'b0, r_hel} + (EL_W + 1)'(i_step_ms);
    assign pel_add = pel_sum[EL_W] ? {EL_W{1'b1}} : pel_sum[EL_W-1:0];
    assign hel_add = hel_sum[EL_W] ? {EL_W{1'b1}} : hel_sum[EL_W-1:0];

    // Zero duration acts as one
    assign dur_enter = (r_enter == '0) ? CFG_W'(1) : r_enter;
    assign dur_exit  = (r_exit == '0) ? CFG_W'(1) : r_exit;

    // Apply one input beat to the phase state
    always_comb begin
        n_phase     = r_phase;
        n_pel       = r_pel;
        n_hel       = r_hel;
        n_opa       = r_opa;
        n_off       = r_off;
        n_need      = 1'b0;
        n_curve_out = r_curve_out;
        n_dur       = r_dur;
        n_rem       = CMP_W'(pel_add) > CMP_W'({CFG_W{1'b1}}) ? '0
                                                              : CFG_W'(CMP_W'(pel_add));
        if (i_func) begin
            n_phase = PH_HIDDEN;
            n_pel   = '0;
            n_hel   = '0;
            n_opa   = OPA_ZERO;
            n_off   = OFF_ENTER_START;
        end else if (r_force) begin
            n_phase = PH_VISIBLE;
            n_opa   = OPA_ONE;
            n_off   = OFF_ZERO;
        end else begin
            unique case (r_phase)
                PH_HIDDEN: begin
                    n_hel = hel_add;
                    n_opa = OPA_ZERO;
                    n_off = OFF_ENTER_START;
                    if (CMP_W'(hel_add) >= CMP_W'(r_interval)) begin
                        n_phase = PH_ENTERING;
                        n_pel   = '0;
                    end
                end
                PH_ENTERING: begin
                    n_pel = pel_add;
                    if (CMP_W'(pel_add) >= CMP_W'(dur_enter)) begin
                        n_phase = PH_VISIBLE;
                        n_pel   = '0;
                        n_opa   = OPA_ONE;
                        n_off   = OFF_ZERO;
                    end else begin
                        n_need      = 1'b1;
                        n_curve_out = 1'b1;
                        n_dur       = dur_enter;
                    end
                end
                PH_VISIBLE: begin
                    n_pel = pel_add;
                    n_opa = OPA_ONE;
                    n_off = OFF_ZERO;
                    if (CMP_W'(pel_add) >= CMP_W'(r_show)) begin
                        n_phase = PH_EXITING;
                        n_pel   = '0;
                    end
                end
                PH_EXITING: begin
                    n_pel = pel_add;
                    if (CMP_W'(pel_add) >= CMP_W'(dur_exit)) begin
                        n_phase = PH_HIDDEN;
                        n_pel   = '0;
                        n_hel   = '0;
                        n_opa   = OPA_ZERO;
                        n_off   = OFF_EXIT_END;
                    end else begin
                        n_need      = 1'b1;
                        n_curve_out = 1'b0;
                        n_dur       = dur_exit;
                    end
                end
            endcase
        end
    end

    // Restoring divider step: one quotient bit per cycle
    assign rem2     = {r_rem, 1'b0};
    assign rem_diff = rem2 - {1'b0, r_dur};
    assign rem_ge   = (rem2 >= {1'b0, r_dur});
    assign rem_next = rem_ge ? rem_diff[CFG_W-1:0] : rem2[CFG_W-1:0];

    // Ease input: one minus progress for ease-out, progress for ease-in
    assign x_val = r_curve_out ? (ONE_F - MUL_W'(r_quo)) : MUL_W'(r_quo);
    assign mag   = r_curve_out ? MAG_ENTER : MAG_EXIT;

    // Shared multiplier with round half up
    always_comb begin
        case (i_cmd.mul_sel)
            MS_SQUARE: begin
                mul_a = x_val;
                mul_b = x_val;
            end
            MS_CUBE: begin
                mul_a = r_p;
                mul_b = x_val;
            end
            MS_SCALE: begin
                mul_a = mag;
                mul_b = r_p;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = (2 * MUL_W + 1)'(mul_a) * (2 * MUL_W + 1)'(mul_b);
    assign prod_rnd = (prod + (2 * MUL_W + 1)'(ONE_F >> 1)) >> FRAC_BITS;
    assign mul_res  = prod_rnd[MUL_W-1:0];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= '0;
            r_enter    <= '0;
            r_show     <= '0;
            r_exit     <= '0;
            r_force    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INTERVAL: r_interval <= i_cfg_data;
                CFG_ENTER:    r_enter    <= i_cfg_data;
                CFG_SHOW:     r_show     <= i_cfg_data;
                CFG_EXIT:     r_exit     <= i_cfg_data;
                CFG_FORCE:    r_force    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Phase state, opacity and offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HIDDEN;
            r_pel       <= '0;
            r_hel       <= '0;
            r_opa       <= OPA_ZERO;
            r_off       <= OFF_ENTER_START;
            r_need      <= 1'b0;
            r_curve_out <= 1'b0;
        end else if (i_cmd.load) begin
            r_phase     <= n_phase;
            r_pel       <= n_pel;
            r_hel       <= n_hel;
            r_opa       <= n_opa;
            r_off       <= n_off;
            r_need      <= n_need;
            r_curve_out <= n_curve_out;
        end else if (i_cmd.mul_en && i_cmd.mul_sel == MS_SCALE) begin
            r_opa <= to_q16(ONE_F - r_p);
            r_off <= OFF_W'(0) - mul_res[OFF_W-1:0];
        end
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + DIV_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dur <= n_dur;
            r_rem <= n_rem;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[FRAC_BITS-2:0], rem_ge};
        end
    end

    // Product register between multiply steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en && i_cmd.mul_sel != MS_SCALE) begin
            r_p <= mul_res;
        end
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_opa    <= r_opa;
            r_out_off    <= r_off;
            r_out_phase  <= r_phase;
            r_out_active <= r_force || (r_phase != PH_HIDDEN);
        end
    end

    assign o_stat.need_ease = r_need;
    assign o_stat.div_last  = (r_cnt == DIV_CW'(FRAC_BITS - 1));

    assign o_opacity_q16     = r_out_opa;
    assign o_slide_offset_q8 = r_out_off;
    assign o_phase           = r_out_phase;
    assign o_active          = r_out_active;

endmodule

// ----- design/efss_ctrl.sv -----
// Controller: sequences load, divide, multiply steps and the result beat.
module efss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output efss_pkg::t_cmd   o_cmd,
    input  efss_pkg::t_stat  i_stat
);
    import efss_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_MUL1  = 7'b0001000,
        ST_MUL2  = 7'b0010000,
        ST_MUL3  = 7'b0100000,
        ST_PUB   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_pub;

    // Output register is free when empty or being drained this cycle
    assign can_pub = !r_out_valid || !i_stall;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MS_SQUARE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.need_ease ? ST_DIV : ST_PUB;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_SQUARE;
                n_state       = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_CUBE;
                n_state       = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_SCALE;
                n_state       = ST_PUB;
            end
            ST_PUB: begin
                if (can_pub) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold the result beat until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- design/eased_fade_slide_sequencer.sv -----
// Top level of the eased fade-and-slide sequencer.
// Each input beat is a time tick (func 0, step_ms elapsed) or a restart (func 1) and
// yields exactly one result beat with opacity (Q16), slide offset (Q8 pixels), phase
// and activity after the beat has been applied. One beat is worked on at a time: a
// restart, a forced-visible tick, a hidden or visible tick, or a tick that finishes
// an entering or exiting fade goes from load through the check to the result beat;
// a mid-fade tick adds the 16-step restoring divider for the progress fraction and
// three passes through the one shared 17x17 multiplier for the cubic curve and the
// offset scale. The next input beat is taken while the previous result beat still
// waits in the output register; a finished beat waits only while that register is
// still full. Configuration writes are applied at once and are meant for idle time.
module eased_fade_slide_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [efss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [efss_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic [efss_pkg::DELTA_W-1:0]      i_step_ms,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [efss_pkg::OPA_W-1:0]        o_opacity_q16,
    output logic signed [efss_pkg::OFF_W-1:0] o_slide_offset_q8,
    output logic [1:0]                        o_phase,
    output logic                              o_active
);
    import efss_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencing
    efss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // Arithmetic and state
    efss_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_func            (i_func),
        .i_step_ms         (i_step_ms),
        .o_opacity_q16     (o_opacity_q16),
        .o_slide_offset_q8 (o_slide_offset_q8),
        .o_phase           (o_phase),
        .o_active          (o_active)
    );

`ifndef ASSERT_OFF
    // An accepted beat blocks the input until its work is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting a beat");

    // An inactive result is always hidden
    a_inactive_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_active) |-> (o_phase == PH_HIDDEN))
        else $error("inactive result outside hidden phase");

    // Visible results are fully opaque and unshifted
    a_visible_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_phase == PH_VISIBLE) |->
        (o_opacity_q16 == OPA_ONE && o_slide_offset_q8 == OFF_ZERO))
        else $error("visible result not at full opacity and zero offset");

    // Hidden results are transparent
    a_hidden_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_phase == PH_HIDDEN) |-> (o_opacity_q16 == OPA_ZERO))
        else $error("hidden result not transparent");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the eased fade-and-slide sequencer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import efss_pkg::*;

    // Beat codes and spare register indexes
    localparam logic FN_TICK    = 1'b0;
    localparam logic FN_RESTART = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [CFG_W-1:0]     SPAN_MAX     = '1;

    // Fixed-point helpers for the prediction
    localparam longint unsigned ONE_Q  = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALF_Q = 64'd1 << (FRAC_BITS - 1);
    localparam longint unsigned EL_MAX = (64'd1 << EL_W) - 1;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_REG  = 4;
    localparam int SETTLE_END  = 30;

    typedef struct packed {
        logic [OPA_W-1:0]        opacity;
        logic signed [OFF_W-1:0] offset;
        t_phase                  phase;
        logic                    active;
    } t_frame;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic                 func;
        logic [DELTA_W-1:0]   delta;
        logic                 typed;
        t_frame               want;
    } t_row;

    // DUT ports
    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data  = '0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    logic                    i_func      = 1'b0;
    logic [DELTA_W-1:0]      i_step_ms   = '0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    logic [OPA_W-1:0]        o_opacity_q16;
    logic signed [OFF_W-1:0] o_slide_offset_q8;
    logic [1:0]              o_phase;
    logic                    o_active;

    // Predicted sequencer state and registers
    t_phase                  seq_phase    = PH_HIDDEN;
    longint unsigned         phase_ms     = 0;
    longint unsigned         hidden_ms    = 0;
    logic [OPA_W-1:0]        held_opa     = OPA_ZERO;
    logic signed [OFF_W-1:0] held_off     = OFF_ENTER_START;
    logic [CFG_W-1:0]        cfg_interval = '0;
    logic [CFG_W-1:0]        cfg_enter    = '0;
    logic [CFG_W-1:0]        cfg_show     = '0;
    logic [CFG_W-1:0]        cfg_exit     = '0;
    logic                    cfg_force    = 1'b0;

    // Expected results, stimulus script and bookkeeping
    t_frame frames_due[$];
    t_row   script[$];
    logic   pin_typed = 1'b0;
    t_frame pin_want  = '0;
    int     gap_pct   = 0;
    int     stall_pct = 0;
    int     quiet_cycles = 0;
    int     faults    = 0;
    int     beats_in  = 0;
    int     beats_out = 0;
    int     restarts  = 0;
    int     reg_writes = 0;

    eased_fade_slide_sequencer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_step_ms         (i_step_ms),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_opacity_q16     (o_opacity_q16),
        .o_slide_offset_q8 (o_slide_offset_q8),
        .o_phase           (o_phase),
        .o_active          (o_active)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned d);
        longint unsigned s;
        s = a + d;
        return (s > EL_MAX) ? EL_MAX : s;
    endfunction

    function automatic longint unsigned qround(longint unsigned a, longint unsigned b);
        return (a * b + HALF_Q) >> FRAC_BITS;
    endfunction

    // Progress through a fade, capped at one
    function automatic longint unsigned progress_q(longint unsigned spent,
                                                   longint unsigned span);
        longint unsigned d;
        longint unsigned q;
        d = (span == 0) ? 1 : span;
        if (spent >= d)
            return ONE_Q;
        q = (spent << FRAC_BITS) / d;
        return (q > ONE_Q) ? ONE_Q : q;
    endfunction

    function automatic logic [OPA_W-1:0] opa_q16(longint unsigned v);
        longint unsigned r;
        if (FRAC_BITS >= 16)
            r = (v + ((64'd1 << Q16_RSH) >> 1)) >> Q16_RSH;
        else
            r = v << Q16_LSH;
        return (r > 65536) ? OPA_ONE : OPA_W'(r);
    endfunction

    function automatic logic signed [OFF_W-1:0] neg_scaled(longint unsigned mag,
                                                          longint unsigned frac);
        logic signed [OFF_W-1:0] m;
        m = OFF_W'((mag * frac + HALF_Q) >> FRAC_BITS);
        return -m;
    endfunction

    // Apply one beat to the predicted state and return the frame it shows
    function automatic t_frame fade_after_beat(logic fn, logic [DELTA_W-1:0] dl);
        longint unsigned t;
        longint unsigned u;
        longint unsigned ease;
        t_frame f;
        if (fn == FN_RESTART) begin
            seq_phase = PH_HIDDEN;
            held_opa  = OPA_ZERO;
            held_off  = OFF_ENTER_START;
            phase_ms  = 0;
            hidden_ms = 0;
        end else if (cfg_force) begin
            seq_phase = PH_VISIBLE;
            held_opa  = OPA_ONE;
            held_off  = OFF_ZERO;
        end else begin
            case (seq_phase)
                PH_HIDDEN: begin
                    hidden_ms = sat_sum(hidden_ms, dl);
                    held_opa  = OPA_ZERO;
                    held_off  = OFF_ENTER_START;
                    if (hidden_ms >= cfg_interval) begin
                        seq_phase = PH_ENTERING;
                        phase_ms  = 0;
                    end
                end
                PH_ENTERING: begin
                    phase_ms = sat_sum(phase_ms, dl);
                    t = progress_q(phase_ms, cfg_enter);
                    if (t >= ONE_Q) begin
                        seq_phase = PH_VISIBLE;
                        phase_ms  = 0;
                        held_opa  = OPA_ONE;
                        held_off  = OFF_ZERO;
                    end else begin
                        // ease-out: one minus the cube of the remaining fraction
                        u    = ONE_Q - t;
                        ease = qround(qround(u, u), u);
                        if (ease > ONE_Q)
                            ease = ONE_Q;
                        held_opa = opa_q16(ONE_Q - ease);
                        held_off = neg_scaled(MAG_ENTER, ease);
                    end
                end
                PH_VISIBLE: begin
                    phase_ms = sat_sum(phase_ms, dl);
                    held_opa = OPA_ONE;
                    held_off = OFF_ZERO;
                    if (phase_ms >= cfg_show) begin
                        seq_phase = PH_EXITING;
                        phase_ms  = 0;
                    end
                end
                default: begin
                    phase_ms = sat_sum(phase_ms, dl);
                    t = progress_q(phase_ms, cfg_exit);
                    if (t >= ONE_Q) begin
                        seq_phase = PH_HIDDEN;
                        phase_ms  = 0;
                        hidden_ms = 0;
                        held_opa  = OPA_ZERO;
                        held_off  = OFF_EXIT_END;
                    end else begin
                        // ease-in: cube of the elapsed fraction
                        ease = qround(qround(t, t), t);
                        if (ease > ONE_Q)
                            ease = ONE_Q;
                        held_opa = opa_q16(ONE_Q - ease);
                        held_off = neg_scaled(MAG_EXIT, ease);
                    end
                end
            endcase
        end
        f.opacity = held_opa;
        f.offset  = held_off;
        f.phase   = seq_phase;
        f.active  = cfg_force || (seq_phase != PH_HIDDEN);
        return f;
    endfunction

    function automatic logic [CFG_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0:         return '0;
            1:         return CFG_W'(1);
            2, 3, 4, 5, 6: return CFG_W'($urandom_range(2, 60));
            7, 8:      return CFG_W'($urandom_range(61, 3000));
            default:   return CFG_W'($urandom_range(3001, 200000));
        endcase
    endfunction

    // Script rows: a beat checked by prediction, a beat with a known frame, a register write
    task automatic beat_row(input logic fn, input logic [DELTA_W-1:0] dl);
        t_row r;
        r       = '0;
        r.kind  = ROW_BEAT;
        r.func  = fn;
        r.delta = dl;
        script.push_back(r);
    endtask

    task automatic known_row(input logic fn, input logic [DELTA_W-1:0] dl,
                             input logic [OPA_W-1:0] opa,
                             input logic signed [OFF_W-1:0] off,
                             input t_phase ph, input logic act);
        t_row r;
        r              = '0;
        r.kind         = ROW_BEAT;
        r.func         = fn;
        r.delta        = dl;
        r.typed        = 1'b1;
        r.want.opacity = opa;
        r.want.offset  = off;
        r.want.phase   = ph;
        r.want.active  = act;
        script.push_back(r);
    endtask

    task automatic reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        t_row r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = data;
        script.push_back(r);
    endtask

    // Drop valid, wait for every expected frame, then let the block settle
    task automatic stream_pause(input int settle);
        if (i_valid) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        while (frames_due.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_beat(input logic fn, input logic [DELTA_W-1:0] dl,
                             input logic typed, input t_frame want);
        // leave random gaps before the beat
        while ($urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_func     <= fn;
        i_step_ms  <= dl;
        pin_typed  = typed;
        pin_want   = want;
        // hold the beat until it is taken
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Receiver back-pressure
    always @(negedge i_clk)
        i_stall <= ($urandom_range(0, 99) < stall_pct);

    // Track register writes and input beats, check every result beat
    always @(posedge i_clk) begin : watch_beats
        t_frame want;
        t_frame got;
        logic   busy;
        busy = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (i_cfg_we === 1'b1) begin
                busy = 1'b1;
                reg_writes++;
                case (i_cfg_index)
                    CFG_INTERVAL: cfg_interval = i_cfg_data;
                    CFG_ENTER:    cfg_enter    = i_cfg_data;
                    CFG_SHOW:     cfg_show     = i_cfg_data;
                    CFG_EXIT:     cfg_exit     = i_cfg_data;
                    CFG_FORCE:    cfg_force    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid === 1'b1 && o_stall === 1'b0) begin
                busy = 1'b1;
                beats_in++;
                if (i_func == FN_RESTART)
                    restarts++;
                want = fade_after_beat(i_func, i_step_ms);
                if (pin_typed)
                    want = pin_want;
                frames_due.push_back(want);
            end
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                busy = 1'b1;
                beats_out++;
                got.opacity = o_opacity_q16;
                got.offset  = o_slide_offset_q8;
                got.phase   = t_phase'(o_phase);
                got.active  = o_active;
                if (frames_due.size() == 0) begin
                    $error("result beat with no frame expected");
                    faults++;
                end else begin
                    want = frames_due.pop_front();
                    if (got.opacity !== want.opacity) begin
                        $error("opacity_q16: expected %0d, got %0d", want.opacity, got.opacity);
                        faults++;
                    end
                    if (got.offset !== want.offset) begin
                        $error("slide_offset_q8: expected %0d, got %0d",
                               want.offset, got.offset);
                        faults++;
                    end
                    if (o_phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, o_phase);
                        faults++;
                    end
                    if (got.active !== want.active) begin
                        $error("active: expected %0d, got %0d", want.active, got.active);
                        faults++;
                    end
                end
            end
            quiet_cycles <= busy ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int                 n;
        int                 restart_pct;
        logic               fn;
        logic [DELTA_W-1:0] dl;

        // Zero-duration cycle straight out of reset
        known_row(FN_TICK, 16'd0, OPA_ZERO, OFF_ENTER_START, PH_ENTERING, 1'b1);
        known_row(FN_TICK, 16'd0, OPA_ZERO, OFF_ENTER_START, PH_ENTERING, 1'b1);
        known_row(FN_TICK, 16'd1, OPA_ONE, OFF_ZERO, PH_VISIBLE, 1'b1);
        known_row(FN_TICK, 16'd0, OPA_ONE, OFF_ZERO, PH_EXITING, 1'b1);
        known_row(FN_TICK, 16'd0, OPA_ONE, OFF_ZERO, PH_EXITING, 1'b1);
        known_row(FN_TICK, 16'hFFFF, OPA_ZERO, OFF_EXIT_END, PH_HIDDEN, 1'b0);
        known_row(FN_RESTART, 16'hFFFF, OPA_ZERO, OFF_ENTER_START, PH_HIDDEN, 1'b0);
        // Short fades with a very long exit
        reg_row(CFG_INTERVAL, 24'd3);
        reg_row(CFG_ENTER, 24'd4);
        reg_row(CFG_SHOW, 24'd2);
        reg_row(CFG_EXIT, SPAN_MAX);
        known_row(FN_TICK, 16'd2, OPA_ZERO, OFF_ENTER_START, PH_HIDDEN, 1'b0);
        beat_row(FN_TICK, 16'd1);
        beat_row(FN_TICK, 16'd1);
        beat_row(FN_TICK, 16'd2);
        known_row(FN_TICK, 16'd1, OPA_ONE, OFF_ZERO, PH_VISIBLE, 1'b1);
        known_row(FN_TICK, 16'd2, OPA_ONE, OFF_ZERO, PH_EXITING, 1'b1);
        beat_row(FN_TICK, 16'hFFFF);
        beat_row(FN_TICK, 16'h5555);
        // Forced visible, restart under force
        reg_row(CFG_EXIT, 24'd5);
        reg_row(CFG_FORCE, 24'd1);
        known_row(FN_TICK, 16'hAAAA, OPA_ONE, OFF_ZERO, PH_VISIBLE, 1'b1);
        known_row(FN_RESTART, 16'h0000, OPA_ZERO, OFF_ENTER_START, PH_HIDDEN, 1'b1);
        known_row(FN_TICK, 16'd0, OPA_ONE, OFF_ZERO, PH_VISIBLE, 1'b1);
        // Release force; spare indexes must not alias onto real registers
        reg_row(CFG_FORCE, 24'd0);
        reg_row(CFG_SPARE_LO, SPAN_MAX);
        reg_row(CFG_SPARE_HI, SPAN_MAX);
        known_row(FN_TICK, 16'd0, OPA_ONE, OFF_ZERO, PH_VISIBLE, 1'b1);
        known_row(FN_TICK, 16'd2, OPA_ONE, OFF_ZERO, PH_EXITING, 1'b1);
        beat_row(FN_TICK, 16'd3);
        known_row(FN_TICK, 16'd2, OPA_ZERO, OFF_EXIT_END, PH_HIDDEN, 1'b0);

        // Hold reset, then release it on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                stream_pause(SETTLE_REG);
                put_reg(script[i].idx, script[i].data);
            end else begin
                send_beat(script[i].func, script[i].delta, script[i].typed, script[i].want);
            end
        end

        // Random phases: each with freshly written registers and an idling mix
        for (int p = 0; p < 6; p++) begin
            stream_pause(SETTLE_REG);
            restart_pct = 6;
            n = 40;
            case (p)
                1:       begin gap_pct = 83; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 83; end
                3, 4:    begin gap_pct = 30; stall_pct = 30; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            if (p == 5) begin
                // longest waits and fades, driven mostly by maximum ticks
                put_reg(CFG_INTERVAL, SPAN_MAX);
                put_reg(CFG_ENTER, SPAN_MAX);
                put_reg(CFG_SHOW, '0);
                put_reg(CFG_EXIT, SPAN_MAX);
                put_reg(CFG_FORCE, '0);
                restart_pct = 0;
                n = 250;
            end else begin
                put_reg(CFG_INTERVAL, pick_span());
                put_reg(CFG_ENTER, pick_span());
                put_reg(CFG_SHOW, pick_span());
                put_reg(CFG_EXIT, pick_span());
                put_reg(CFG_FORCE, (p == 4) ? CFG_W'(1) : '0);
            end
            for (int k = 0; k < n; k++) begin
                fn = ($urandom_range(0, 99) < restart_pct) ? FN_RESTART : FN_TICK;
                if (p == 5) begin
                    dl = ($urandom_range(0, 99) < 85) ? '1 : DELTA_W'($urandom);
                end else begin
                    case ($urandom_range(0, 19))
                        0:             dl = '0;
                        1:             dl = '1;
                        2, 3, 4:       dl = DELTA_W'($urandom);
                        5, 6, 7, 8, 9: dl = DELTA_W'($urandom_range(0, 400));
                        default:       dl = DELTA_W'($urandom_range(0, 20));
                    endcase
                end
                send_beat(fn, dl, 1'b0, '0);
            end
        end

        gap_pct = 0;
        stream_pause(SETTLE_END);
        $display("Drove %0d beats (%0d restarts) and %0d register writes; checked %0d results.",
                 beats_in, restarts, reg_writes, beats_out);
        $display("Covered zero, short, forced-visible and maximum durations under four idling mixes.");
        if (faults == 0 && frames_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
